// ----- sv/ddo_pkg.sv -----
// ----------------------------------------------------------------------------
// ddo_pkg: shared types and constants for the odometry block
// Beat payload structs, register indexes, CORDIC constants and the arctangent
// table.
// ----------------------------------------------------------------------------
package ddo_pkg;

  typedef struct packed {
    logic signed [31:0] right_count;
    logic signed [31:0] left_count;
  } in_beat_t;

  typedef struct packed {
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic        [31:0] heading;
    logic signed [31:0] heading_step;
    logic signed [31:0] distance_step;
    logic signed [47:0] robot_speed;
    logic signed [47:0] right_speed;
    logic signed [47:0] left_speed;
    logic signed [31:0] right_tick_step;
    logic signed [31:0] left_tick_step;
  } out_beat_t;

  // front -> back: raw wheel steps of one sample
  typedef struct packed {
    logic signed [31:0] rraw;
    logic signed [31:0] lraw;
  } step_t;

  typedef struct packed {
    logic [17:0] rgain;
    logic [17:0] lgain;
    logic [31:0] mmpt;
    logic [23:0] hpmm;
    logic [15:0] srate;
  } cfg_t;

  localparam logic [2:0] REG_RGAIN = 3'd0;
  localparam logic [2:0] REG_LGAIN = 3'd1;
  localparam logic [2:0] REG_MMPT  = 3'd2;
  localparam logic [2:0] REG_HPMM  = 3'd3;
  localparam logic [2:0] REG_SRATE = 3'd4;

  localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] t;
    case (i)
      5'd0: t = 32'h20000000;  5'd1: t = 32'h12E4051E;  5'd2: t = 32'h09FB385B;
      5'd3: t = 32'h051111D4;  5'd4: t = 32'h028B0D43;  5'd5: t = 32'h0145D7E1;
      5'd6: t = 32'h00A2F61E;  5'd7: t = 32'h00517C55;  5'd8: t = 32'h0028BE53;
      5'd9: t = 32'h00145F2F;  5'd10: t = 32'h000A2F98; 5'd11: t = 32'h000517CC;
      5'd12: t = 32'h00028BE6; 5'd13: t = 32'h000145F3; 5'd14: t = 32'h0000A2FA;
      5'd15: t = 32'h0000517D; 5'd16: t = 32'h000028BE; 5'd17: t = 32'h0000145F;
      5'd18: t = 32'h00000A30; 5'd19: t = 32'h00000518; 5'd20: t = 32'h0000028C;
      5'd21: t = 32'h00000146; 5'd22: t = 32'h000000A3; 5'd23: t = 32'h00000051;
      5'd24: t = 32'h00000029; 5'd25: t = 32'h00000014; 5'd26: t = 32'h0000000A;
      5'd27: t = 32'h00000005; 5'd28: t = 32'h00000003; 5'd29: t = 32'h00000001;
      5'd30: t = 32'h00000001; default: t = 32'h00000000;
    endcase
    return t;
  endfunction

endpackage

// ----- sv/ddo_front.sv -----
// ----------------------------------------------------------------------------
// ddo_front: sample intake
// Differences each count beat against the previous one and pushes the raw
// wheel steps into a two-entry queue.
// ----------------------------------------------------------------------------
module ddo_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ddo_pkg::in_beat_t  in_data,
  output logic               q_valid,
  input  logic               q_pop,
  output ddo_pkg::step_t     q_data
);
  logic [31:0]     prev_r_r, prev_l_r;
  ddo_pkg::step_t  mem_r [2];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r;
  logic            push;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r_r <= '0;
      prev_l_r <= '0;
      wp_r     <= 1'b0;
      rp_r     <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        prev_r_r <= in_data.right_count;
        prev_l_r <= in_data.left_count;
        wp_r     <= !wp_r;
      end
      if (q_pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r].rraw <= in_data.right_count - prev_r_r;
      mem_r[wp_r].lraw <= in_data.left_count - prev_l_r;
    end
  end
endmodule

// ----- sv/ddo_back.sv -----
// ----------------------------------------------------------------------------
// ddo_back: odometry sequencer
// One shared multiplier walks through the per-sample products, a CORDIC
// rotates the new heading, then positions and speeds are formed.
// ----------------------------------------------------------------------------
module ddo_back #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ddo_pkg::cfg_t      cfg,
  input  logic               q_valid,
  output logic               q_pop,
  input  ddo_pkg::step_t     q_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ddo_pkg::out_beat_t out_data
);
  localparam int IW = $clog2(CORDIC_STEPS + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_CORD = 7'b0000100,
    S_POS  = 7'b0001000,
    S_SPD  = 7'b0010000,
    S_DONE = 7'b0100000,
    S_OUT  = 7'b1000000
  } st_t;

  st_t st_r, st_nxt;
  logic [2:0]  op_r;
  logic [IW-1:0] it_r;

  logic signed [31:0] rraw_r, lraw_r, rt_r, lt_r, dr_r, dl_r, d_r, hs_r;
  logic [31:0]        hd_r;
  logic signed [47:0] x_r, y_r, rs_r, ls_r, ds_r;
  logic signed [33:0] cx_r, cy_r;
  logic signed [32:0] cz_r;
  logic               flip_r;

  // shared multiplier, 33x34 signed
  logic signed [32:0] ma;
  logic signed [33:0] mb;
  logic signed [66:0] mp;
  assign mp = ma * mb;

  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    if (v > 67'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -67'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic signed [66:0] rnd24, rnd16, rnd30;
  assign rnd24 = (mp + 67'sd8388608) >>> 24;
  assign rnd16 = (mp + 67'sd32768) >>> 16;
  assign rnd30 = (mp + 67'sd536870912) >>> 30;

  always_comb begin
    ma = '0;
    mb = '0;
    case (st_r)
      S_MUL: begin
        case (op_r)
          3'd0: begin ma = 33'(rraw_r); mb = 34'(cfg.rgain); end
          3'd1: begin ma = 33'(lraw_r); mb = 34'(cfg.lgain); end
          3'd2: begin ma = 33'(rt_r);   mb = 34'(cfg.mmpt); end
          3'd3: begin ma = 33'(lt_r);   mb = 34'(cfg.mmpt); end
          default: begin ma = 33'(dl_r) - 33'(dr_r); mb = 34'(cfg.hpmm); end
        endcase
      end
      S_POS: begin
        ma = 33'(d_r);
        mb = (op_r == 3'd0) ? (flip_r ? -cy_r : cy_r) : (flip_r ? -cx_r : cx_r);
      end
      S_SPD: begin
        mb = 34'(cfg.srate);
        case (op_r)
          3'd0: ma = 33'(d_r);
          3'd1: ma = 33'(dr_r);
          default: ma = 33'(dl_r);
        endcase
      end
      default: ;
    endcase
  end

  logic signed [33:0] xs, ys;
  logic [31:0]        at;
  assign xs = cx_r >>> it_r;
  assign ys = cy_r >>> it_r;
  assign at = ddo_pkg::atan_lut(5'(it_r));

  // new heading uses this sample's step straight off the multiplier
  logic [31:0] hnew, hfl;
  logic        fl;
  assign hnew = hd_r + rnd16[31:0];
  assign fl   = hnew[31] ^ hnew[30];
  assign hfl  = fl ? (hnew ^ 32'h80000000) : hnew;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (q_valid) st_nxt = S_MUL;
      S_MUL:  if (op_r == 3'd4) st_nxt = S_CORD;
      S_CORD: if (it_r == IW'(CORDIC_STEPS - 1)) st_nxt = S_POS;
      S_POS:  if (op_r == 3'd1) st_nxt = S_SPD;
      S_SPD:  if (op_r == 3'd2) st_nxt = S_DONE;
      S_DONE: st_nxt = S_OUT;
      S_OUT:  if (!out_stall) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  assign q_pop     = (st_r == S_IDLE) && q_valid;
  assign out_valid = (st_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      op_r <= '0;
      it_r <= '0;
      hd_r <= '0;
      x_r  <= '0;
      y_r  <= '0;
    end else begin
      st_r <= st_nxt;
      op_r <= (st_nxt != st_r) ? 3'd0 : op_r + 3'd1;
      case (st_r)
        S_IDLE: if (q_valid) begin
          rraw_r <= q_data.rraw;
          lraw_r <= q_data.lraw;
        end
        S_MUL: begin
          case (op_r)
            3'd0: rt_r <= sat32(mp);
            3'd1: lt_r <= sat32(mp);
            3'd2: dr_r <= sat32(rnd24);
            3'd3: begin
              dl_r <= sat32(rnd24);
              d_r  <= 32'((33'(dr_r) + 33'(sat32(rnd24))) >>> 1);
            end
            default: begin
              hs_r   <= rnd16[31:0];
              hd_r   <= hnew;
              flip_r <= fl;
              cx_r   <= ddo_pkg::CORDIC_K;
              cy_r   <= '0;
              cz_r   <= 33'($signed(hfl));
              it_r   <= '0;
            end
          endcase
        end
        S_CORD: begin
          if (!cz_r[32]) begin
            cx_r <= cx_r - ys; cy_r <= cy_r + xs; cz_r <= cz_r - 33'(at);
          end else begin
            cx_r <= cx_r + ys; cy_r <= cy_r - xs; cz_r <= cz_r + 33'(at);
          end
          it_r <= it_r + 1'b1;
        end
        S_POS: begin
          if (op_r == 3'd0) x_r <= x_r + rnd30[47:0];
          else              y_r <= y_r + rnd30[47:0];
        end
        S_SPD: begin
          case (op_r)
            3'd0: ds_r <= mp[47:0];
            3'd1: rs_r <= mp[47:0];
            default: ls_r <= mp[47:0];
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_DONE) begin
      out_data.pos_x           <= x_r;
      out_data.pos_y           <= y_r;
      out_data.heading         <= hd_r;
      out_data.heading_step    <= hs_r;
      out_data.distance_step   <= d_r;
      out_data.robot_speed     <= ds_r;
      out_data.right_speed     <= rs_r;
      out_data.left_speed      <= ls_r;
      out_data.right_tick_step <= rt_r;
      out_data.left_tick_step  <= lt_r;
    end
  end
endmodule

// ----- sv/differential_drive_odometry.sv -----
// ----------------------------------------------------------------------------
// differential_drive_odometry: dead-reckoning position tracker
// Encoder count beats in, pose and speed beats out; APB register port.
// ----------------------------------------------------------------------------
// Flow: a beat enters the step queue; the back end then runs MUL, CORD, POS,
//   SPD, DONE and OUT and takes one sample at a time, as set by the back end's
//   single shared multiplier and iterative CORDIC; a two-deep queue buffers.
// Reset: synchronous active-low; clears counts, heading, position, queue and
//   reloads register defaults.
module differential_drive_odometry #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ddo_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ddo_pkg::out_beat_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  ddo_pkg::cfg_t   cfg_r;
  ddo_pkg::step_t  q_data;
  logic            q_valid, q_pop;
  logic [2:0]      ridx;

  assign cfg_pready = 1'b1;
  assign ridx       = cfg_paddr[4:2];

  // register file; writes land on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rgain <= 18'd65536;
      cfg_r.lgain <= 18'd65536;
      cfg_r.mmpt  <= 32'd16777216;
      cfg_r.hpmm  <= 24'd1367130;
      cfg_r.srate <= 16'd100;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (ridx)
        ddo_pkg::REG_RGAIN: cfg_r.rgain <= cfg_pwdata[17:0];
        ddo_pkg::REG_LGAIN: cfg_r.lgain <= cfg_pwdata[17:0];
        ddo_pkg::REG_MMPT:  cfg_r.mmpt  <= cfg_pwdata;
        ddo_pkg::REG_HPMM:  cfg_r.hpmm  <= cfg_pwdata[23:0];
        ddo_pkg::REG_SRATE: cfg_r.srate <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (ridx)
      ddo_pkg::REG_RGAIN: cfg_prdata = 32'(cfg_r.rgain);
      ddo_pkg::REG_LGAIN: cfg_prdata = 32'(cfg_r.lgain);
      ddo_pkg::REG_MMPT:  cfg_prdata = cfg_r.mmpt;
      ddo_pkg::REG_HPMM:  cfg_prdata = 32'(cfg_r.hpmm);
      ddo_pkg::REG_SRATE: cfg_prdata = 32'(cfg_r.srate);
      default: ;
    endcase
  end

  // front: count differencing and step queue
  ddo_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .q_valid, .q_pop, .q_data
  );

  // back: multiply sequence, CORDIC, accumulation
  ddo_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk, .rst_n, .cfg(cfg_r), .q_valid, .q_pop, .q_data,
    .out_valid, .out_stall, .out_data
  );

  a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat dropped under stall");
  a_no_pop_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !q_pop) else $error("back end took a beat while busy");
endmodule

// ----- tb/differential_drive_odometry_test.sv -----
// ----------------------------------------------------------------------------
// differential_drive_odometry_test: self-checking bench for the odometry block
// Drives encoder count beats through random valid/stall pressure, predicts
// every pose/speed beat with a local fixed-point model and compares fields.
// ----------------------------------------------------------------------------
module differential_drive_odometry_test;

  localparam int NSTEPS = 24;
  localparam int LIMIT  = 1000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ddo_pkg::in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ddo_pkg::out_beat_t out_data;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  differential_drive_odometry #(.CORDIC_STEPS(NSTEPS)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor copy of registers and odometry state
  logic [17:0] rgain_m, lgain_m;
  logic [31:0] mmpt_m;
  logic [23:0] hpmm_m;
  logic [15:0] srate_m;
  logic [31:0] prev_r, prev_l, head_m;
  logic [47:0] xpos_m, ypos_m;

  ddo_pkg::out_beat_t pose_q[$];
  int errors = 0;
  int cycles = 0;
  int send_idle = 0;   // percent
  int recv_stall = 0;  // percent

  // arithmetic shift: SystemVerilog >>> on signed longint is floor already
  function automatic longint clamp(input longint v, input int bits);
    longint hi, lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint sext32(input logic [31:0] v);
    return longint'($signed(v));
  endfunction

  // CORDIC rotation in Q2.30; angle folded by a half-turn flip
  task automatic rotate_angle(input logic [31:0] ang, output longint s, output longint c);
    logic flip;
    logic [31:0] a, sum;
    longint z, x, y, xs, ys;
    sum = ang + 32'h40000000;
    flip = sum[31];
    a = flip ? (ang ^ 32'h80000000) : ang;
    z = sext32(a);
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < NSTEPS && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(ddo_pkg::atan_lut(i[4:0]));
      end else begin
        x += ys; y -= xs; z += longint'(ddo_pkg::atan_lut(i[4:0]));
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  task automatic predict_pose(input ddo_pkg::in_beat_t b);
    ddo_pkg::out_beat_t e;
    longint rraw, lraw, rt, lt, dr, dl, d, hraw, s, c;
    logic [31:0] hstep;
    rraw = sext32(b.right_count - prev_r);
    lraw = sext32(b.left_count - prev_l);
    rt = clamp(rraw * longint'(rgain_m), 32);
    lt = clamp(lraw * longint'(lgain_m), 32);
    dr = clamp((rt * longint'(mmpt_m) + (64'sd1 <<< 23)) >>> 24, 32);
    dl = clamp((lt * longint'(mmpt_m) + (64'sd1 <<< 23)) >>> 24, 32);
    d = (dr + dl) >>> 1;
    hraw = ((dl - dr) * longint'(hpmm_m) + (64'sd1 <<< 15)) >>> 16;
    hstep = hraw[31:0];
    prev_r = b.right_count;
    prev_l = b.left_count;
    head_m = head_m + hstep;
    rotate_angle(head_m, s, c);
    xpos_m = xpos_m + 48'((d * s + (64'sd1 <<< 29)) >>> 30);
    ypos_m = ypos_m + 48'((d * c + (64'sd1 <<< 29)) >>> 30);
    e.pos_x = xpos_m;
    e.pos_y = ypos_m;
    e.heading = head_m;
    e.heading_step = hstep;
    e.distance_step = d[31:0];
    e.robot_speed = 48'(clamp(d * longint'(srate_m), 48));
    e.right_speed = 48'(clamp(dr * longint'(srate_m), 48));
    e.left_speed = 48'(clamp(dl * longint'(srate_m), 48));
    e.right_tick_step = rt[31:0];
    e.left_tick_step = lt[31:0];
    pose_q.push_back(e);
  endtask

  // output side: random stall, compare on accepted beats
  always @(negedge clk) begin
    if (rst_n) out_stall <= ($urandom_range(99) < recv_stall);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (pose_q.size() == 0) begin
        $error("unexpected beat: pos_x %0h", out_data.pos_x);
        errors++;
      end else begin
        ddo_pkg::out_beat_t e;
        e = pose_q.pop_front();
        if (e.pos_x !== out_data.pos_x) begin
          $error("pos_x exp %0h got %0h", e.pos_x, out_data.pos_x); errors++;
        end
        if (e.pos_y !== out_data.pos_y) begin
          $error("pos_y exp %0h got %0h", e.pos_y, out_data.pos_y); errors++;
        end
        if (e.heading !== out_data.heading) begin
          $error("heading exp %0h got %0h", e.heading, out_data.heading); errors++;
        end
        if (e.heading_step !== out_data.heading_step) begin
          $error("heading_step exp %0h got %0h", e.heading_step, out_data.heading_step);
          errors++;
        end
        if (e.distance_step !== out_data.distance_step) begin
          $error("distance_step exp %0h got %0h", e.distance_step,
                 out_data.distance_step);
          errors++;
        end
        if (e.robot_speed !== out_data.robot_speed) begin
          $error("robot_speed exp %0h got %0h", e.robot_speed, out_data.robot_speed);
          errors++;
        end
        if (e.right_speed !== out_data.right_speed) begin
          $error("right_speed exp %0h got %0h", e.right_speed, out_data.right_speed);
          errors++;
        end
        if (e.left_speed !== out_data.left_speed) begin
          $error("left_speed exp %0h got %0h", e.left_speed, out_data.left_speed);
          errors++;
        end
        if (e.right_tick_step !== out_data.right_tick_step) begin
          $error("right_tick_step exp %0h got %0h", e.right_tick_step,
                 out_data.right_tick_step);
          errors++;
        end
        if (e.left_tick_step !== out_data.left_tick_step) begin
          $error("left_tick_step exp %0h got %0h", e.left_tick_step,
                 out_data.left_tick_step);
          errors++;
        end
      end
    end
  end

  // watchdog: far beyond what the 949 beats need, stalls and gaps included
  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // one input beat; valid dropped only when idling follows
  task automatic send_counts(input logic [31:0] r, input logic [31:0] l);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data.right_count <= r;
    in_data.left_count <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pose('{right_count: r, left_count: l});
    @(negedge clk);
  endtask

  task automatic go_quiet();
    in_valid <= 1'b0;
    while (pose_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // APB write, block idle; register index by name
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      ddo_pkg::REG_RGAIN: rgain_m = val[17:0];
      ddo_pkg::REG_LGAIN: lgain_m = val[17:0];
      ddo_pkg::REG_MMPT:  mmpt_m = val;
      ddo_pkg::REG_HPMM:  hpmm_m = val[23:0];
      ddo_pkg::REG_SRATE: srate_m = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  task automatic set_all(input logic [17:0] rg, input logic [17:0] lg,
                         input logic [31:0] mm, input logic [23:0] hp,
                         input logic [15:0] sr);
    go_quiet();
    write_reg(ddo_pkg::REG_RGAIN, 32'(rg));
    write_reg(ddo_pkg::REG_LGAIN, 32'(lg));
    write_reg(ddo_pkg::REG_MMPT, mm);
    write_reg(ddo_pkg::REG_HPMM, 32'(hp));
    write_reg(ddo_pkg::REG_SRATE, 32'(sr));
  endtask

  // extremes of counts, counter wrap, big gains to saturate distances
  task automatic test_directed();
    send_idle = 0; recv_stall = 0;
    send_counts(32'd0, 32'd0);
    send_counts(32'd100, 32'd100);
    send_counts(32'd200, 32'd150);
    send_counts(32'h7FFFFFFF, 32'h80000000);   // counter wrap, both signs
    send_counts(32'h80000000, 32'h7FFFFFFF);
    send_counts(32'hFFFFFFFF, 32'h00000000);
    // heading wrap: many large left-minus-right steps
    for (int i = 1; i <= 6; i++) send_counts(32'd0 - 32'(i * 40000), 32'(i * 40000));
    // distance saturation with maximal gain and scale
    set_all(18'h3FFFF, 18'h3FFFF, 32'hFFFFFFFF, 24'hFFFFFF, 16'hFFFF);
    send_counts(32'h7FFFFFFF, 32'h80000000);
    send_counts(32'h00000000, 32'hFFFFFFFF);
    send_counts(32'h00001000, 32'h00000010);
    // zero gains, zero rate, unknown register index ignored
    set_all(18'd0, 18'd0, 32'd0, 24'd0, 16'd0);
    write_reg(3'd7, 32'hFFFFFFFF);
    send_counts(32'h12345678, 32'h87654321);
    send_counts(32'h00000000, 32'h00000000);
    // gain change between samples: new gain applies to whole step
    set_all(18'h10000, 18'h20000, 32'h01000000, 24'd1367130, 16'd1);
    send_counts(32'd500, 32'd500);
    set_all(18'h08000, 18'h10000, 32'h00800000, 24'd1367130, 16'd1000);
    send_counts(32'd1000, 32'd900);
  endtask

  // realistic small count deltas, occasional big jumps
  task automatic test_random(input int n);
    logic [31:0] r, l;
    r = prev_r; l = prev_l;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        r = $urandom; l = $urandom;
      end else begin
        r = r + 32'($signed($urandom_range(4000)) - 2000);
        l = l + 32'($signed($urandom_range(4000)) - 2000);
      end
      send_counts(r, l);
    end
  endtask

  task automatic test_pressure();
    send_idle = 0; recv_stall = 0;   test_random(200);
    send_idle = 76; recv_stall = 0;  test_random(150);
    // hold off until everything has drained
    in_valid <= 1'b0;
    while (pose_q.size() != 0) @(negedge clk);
    send_idle = 0; recv_stall = 76;  test_random(150);
    set_all(18'($urandom), 18'($urandom), $urandom, 24'($urandom),
            16'($urandom_range(65535, 1)));
    send_idle = 36; recv_stall = 36; test_random(200);
    set_all(18'h10000, 18'h0FF00, 32'h00A00000, 24'd2000000, 16'd100);
    send_idle = 0; recv_stall = 0;   test_random(230);
  endtask

  initial begin
    rgain_m = 18'd65536; lgain_m = 18'd65536; mmpt_m = 32'd16777216;
    hpmm_m = 24'd1367130; srate_m = 16'd100;
    prev_r = '0; prev_l = '0; head_m = '0; xpos_m = '0; ypos_m = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_pressure();
    go_quiet();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/ddo_pkg.sv
sv/ddo_front.sv
sv/ddo_back.sv
sv/differential_drive_odometry.sv
tb/differential_drive_odometry_test.sv
